FILE: rtl/fdc_pkg.sv
// ----------------------------------------------------------------------------
// fdc_pkg
// Types, constants and helper functions shared by the frame de-whitening and
// block CRC check unit.
// ----------------------------------------------------------------------------
package fdc_pkg;

   localparam int unsigned WHITEN_LEN   = 64;
   localparam int unsigned WHITEN_IDX_W = $clog2(WHITEN_LEN);

   localparam logic [8:0]  HEADER_BYTES = 9'd8;
   localparam logic [8:0]  POS_MAX      = 9'd511;
   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_INIT     = 16'hFFFF;

   localparam logic [8:0]  FRAME_LENGTH_RESET = 9'd320;
   localparam logic [7:0]  FIRST_BLOCK_RESET  = 8'd57;

   // configuration register indexes
   localparam logic CSR_FRAME_LENGTH = 1'b0;
   localparam logic CSR_FIRST_BLOCK  = 1'b1;

   localparam logic [7:0] WHITEN_TABLE [WHITEN_LEN] = '{
      8'd150, 8'd131, 8'd62,  8'd81,  8'd177, 8'd73,  8'd8,   8'd152,
      8'd50,  8'd5,   8'd89,  8'd14,  8'd249, 8'd68,  8'd198, 8'd38,
      8'd33,  8'd96,  8'd194, 8'd234, 8'd121, 8'd93,  8'd109, 8'd161,
      8'd84,  8'd105, 8'd71,  8'd12,  8'd220, 8'd232, 8'd92,  8'd241,
      8'd247, 8'd118, 8'd130, 8'd127, 8'd7,   8'd153, 8'd162, 8'd44,
      8'd147, 8'd124, 8'd48,  8'd99,  8'd245, 8'd16,  8'd46,  8'd97,
      8'd208, 8'd188, 8'd180, 8'd182, 8'd6,   8'd170, 8'd244, 8'd35,
      8'd120, 8'd110, 8'd59,  8'd174, 8'd191, 8'd123, 8'd76,  8'd193
   };

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] clear_byte;
      logic [8:0] byte_position;
      logic       block_done;
      logic [7:0] block_type;
      logic [7:0] block_length;
      logic       crc_good;
      logic       block_truncated;
      logic       frame_done;
      logic       frame_ok;
   } rsp_type;

   // classified byte passed from the front end to the parser
   typedef struct packed {
      logic [7:0] clear_byte;
      logic [8:0] byte_position;
      logic       frame_start;
   } byte_type;

   function automatic logic [7:0] bit_reverse(input logic [7:0] value);
      logic [7:0] result;
      for (int k = 0; k < 8; k++) begin
         result[k] = value[7 - k];
      end
      return result;
   endfunction

   // one byte of CRC-16, MSB first, no reflection
   function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/fdc_queue.sv
// ----------------------------------------------------------------------------
// fdc_queue
// Small first-in first-out queue; the oldest entry is shown while not empty.
// ----------------------------------------------------------------------------
module fdc_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/fdc_front.sv
// ----------------------------------------------------------------------------
// fdc_front
// Tracks frame position, bit-reverses and de-whitens each received byte.
// ----------------------------------------------------------------------------
module fdc_front
   import fdc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     accept,
   input  req_type  req,
   output byte_type classified
);

   logic [8:0] position_ff, position_in;
   logic [8:0] pos;

   always_comb begin
      pos = req.frame_start ? HEADER_BYTES : position_ff;
      classified.byte_position = pos;
      classified.frame_start   = req.frame_start;
      classified.clear_byte    = bit_reverse(req.raw_byte)
                                 ^ WHITEN_TABLE[pos[WHITEN_IDX_W-1:0]];
      // saturate at the top of the position range
      position_in = (pos < POS_MAX) ? pos + 9'd1 : POS_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= HEADER_BYTES;
      end else if (accept) begin
         position_ff <= position_in;
      end
   end

endmodule

FILE: rtl/fdc_parser.sv
// ----------------------------------------------------------------------------
// fdc_parser
// Block parser: type, length, data and CRC bytes; reports block and frame
// status for every byte.
// ----------------------------------------------------------------------------
module fdc_parser
   import fdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [8:0] csr_data,
   input  logic       fire,
   input  byte_type   classified,
   output rsp_type    result
);

   typedef enum logic [2:0] {
      PH_WAIT, PH_TYPE, PH_LEN, PH_DATA, PH_CRCLO, PH_CRCHI, PH_STOP, PH_OVER
   } phase_type;

   logic [8:0]  frame_length_ff;
   logic [7:0]  first_block_ff;

   phase_type   phase_ff, phase_in, s_phase;
   logic [7:0]  type_ff, type_in, s_type;
   logic [7:0]  length_ff, length_in, s_length;
   logic [7:0]  left_ff, left_in, s_left;
   logic [15:0] crc_ff, crc_in, s_crc;
   logic [7:0]  crc_low_ff, crc_low_in, s_crc_low;
   logic        any_good_ff, any_good_in, s_any_good;

   logic [9:0]  pos_ext, pos_next, len_ext, end_pos;
   logic [7:0]  clear;
   logic        good;

   always_comb begin
      clear    = classified.clear_byte;
      pos_ext  = {1'b0, classified.byte_position};
      pos_next = pos_ext + 10'd1;
      len_ext  = {1'b0, frame_length_ff};
      end_pos  = pos_ext + 10'd3 + {2'b00, clear};

      // a frame start wipes the parse state before this byte is handled
      s_phase    = classified.frame_start ? PH_WAIT  : phase_ff;
      s_type     = classified.frame_start ? 8'd0     : type_ff;
      s_length   = classified.frame_start ? 8'd0     : length_ff;
      s_left     = classified.frame_start ? 8'd0     : left_ff;
      s_crc      = classified.frame_start ? CRC_INIT : crc_ff;
      s_crc_low  = classified.frame_start ? 8'd0     : crc_low_ff;
      s_any_good = classified.frame_start ? 1'b0     : any_good_ff;

      phase_in    = s_phase;
      type_in     = s_type;
      length_in   = s_length;
      left_in     = s_left;
      crc_in      = s_crc;
      crc_low_in  = s_crc_low;
      any_good_in = s_any_good;

      good   = (s_crc_low == s_crc[7:0]) && (clear == s_crc[15:8]);
      result = '0;
      result.clear_byte    = clear;
      result.byte_position = classified.byte_position;

      case (s_phase)
         PH_WAIT, PH_TYPE: begin
            if (s_phase == PH_TYPE ||
                classified.byte_position == {1'b0, first_block_ff}) begin
               if (pos_ext >= len_ext) begin
                  phase_in = PH_STOP;
               end else if (pos_next == len_ext) begin
                  result.block_truncated = 1'b1;
                  phase_in = PH_STOP;
               end else begin
                  type_in  = clear;
                  phase_in = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            length_in = clear;
            if (end_pos > len_ext) begin
               result.block_truncated = 1'b1;
               phase_in = PH_STOP;
            end else begin
               crc_in   = CRC_INIT;
               left_in  = clear;
               phase_in = (clear != 8'd0) ? PH_DATA : PH_CRCLO;
            end
         end
         PH_DATA: begin
            crc_in  = crc_update(s_crc, clear);
            left_in = s_left - 8'd1;
            if (left_in == 8'd0) begin
               phase_in = PH_CRCLO;
            end
         end
         PH_CRCLO: begin
            crc_low_in = clear;
            phase_in   = PH_CRCHI;
         end
         PH_CRCHI: begin
            result.block_done   = 1'b1;
            result.block_type   = s_type;
            result.block_length = s_length;
            result.crc_good     = good;
            any_good_in         = s_any_good | good;
            phase_in            = PH_TYPE;
         end
         default: begin
         end
      endcase

      if (s_phase != PH_OVER && pos_next == len_ext) begin
         result.frame_done = 1'b1;
         result.frame_ok   = any_good_in;
         phase_in          = PH_OVER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= FRAME_LENGTH_RESET;
         first_block_ff  <= FIRST_BLOCK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FRAME_LENGTH: frame_length_ff <= csr_data;
            CSR_FIRST_BLOCK:  first_block_ff  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT;
         type_ff     <= 8'd0;
         length_ff   <= 8'd0;
         left_ff     <= 8'd0;
         crc_ff      <= CRC_INIT;
         crc_low_ff  <= 8'd0;
         any_good_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         crc_ff      <= crc_in;
         crc_low_ff  <= crc_low_in;
         any_good_ff <= any_good_in;
      end
   end

endmodule

FILE: rtl/frame_descramble_block_crc_check_unit.sv
// A pushed byte goes into the byte queue, then on a fire into the result queue.
// Throughput: one byte per cycle sustained; the parser handles one byte each cycle
// and the byte queue and result queue let either side stall on its own.
// Reset: synchronous, active high; empties both queues, sets position to 8,
// frame_length to 320 and first_block_position to 57, parser waits for a block.
// ----------------------------------------------------------------------------
// frame_descramble_block_crc_check_unit
// De-whitens received frame bytes and checks CRC-16 protected blocks.
// ----------------------------------------------------------------------------
module frame_descramble_block_crc_check_unit
   import fdc_pkg::*;
#(
   parameter int unsigned BYTE_QUEUE_DEPTH   = 2,
   parameter int unsigned RESULT_QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [8:0] csr_data
);

   logic     req_accept;
   byte_type front_byte;
   byte_type head_byte;
   logic     byte_empty;
   logic     result_full;
   logic     fire;
   rsp_type  result;

   assign req_accept = req_push && !req_full;
   // advance the parser only when a byte waits and the result has room
   assign fire       = !byte_empty && !result_full;

   fdc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_data),
      .classified (front_byte)
   );

   fdc_queue #(
      .WIDTH ($bits(byte_type)),
      .DEPTH (BYTE_QUEUE_DEPTH)
   ) u_byte_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_push),
      .wr_data (front_byte),
      .full    (req_full),
      .rd_en   (fire),
      .rd_data (head_byte),
      .empty   (byte_empty)
   );

   fdc_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fire       (fire),
      .classified (head_byte),
      .result     (result)
   );

   fdc_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fire),
      .wr_data (result),
      .full    (result_full),
      .rd_en   (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty)
   );

endmodule

FILE: verif/tb_frame_descramble_block_crc_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_descramble_block_crc_check_unit
// Self-checking bench for the frame de-whitening and block CRC check unit.
// A table of directed bytes and register writes runs first. Random frames
// follow, mostly well-formed block chains with good or broken CRCs and some
// noise. Results are checked against a bit-level predictor or a pinned row.
// ----------------------------------------------------------------------------
module tb_frame_descramble_block_crc_check_unit;
   import fdc_pkg::req_type;
   import fdc_pkg::rsp_type;
   import fdc_pkg::CSR_FRAME_LENGTH;
   import fdc_pkg::CSR_FIRST_BLOCK;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_ITEMS = 440;
   localparam int          LONG_HOLD    = 80;
   localparam logic [8:0]  HEADER_POS   = 9'd8;
   localparam logic [8:0]  POS_LAST     = 9'd511;
   localparam logic [15:0] CCITT_POLY   = 16'h1021;
   localparam logic [15:0] CCITT_INIT   = 16'hFFFF;

   localparam logic [7:0] WHITEN [64] = '{
      8'd150, 8'd131, 8'd62,  8'd81,  8'd177, 8'd73,  8'd8,   8'd152,
      8'd50,  8'd5,   8'd89,  8'd14,  8'd249, 8'd68,  8'd198, 8'd38,
      8'd33,  8'd96,  8'd194, 8'd234, 8'd121, 8'd93,  8'd109, 8'd161,
      8'd84,  8'd105, 8'd71,  8'd12,  8'd220, 8'd232, 8'd92,  8'd241,
      8'd247, 8'd118, 8'd130, 8'd127, 8'd7,   8'd153, 8'd162, 8'd44,
      8'd147, 8'd124, 8'd48,  8'd99,  8'd245, 8'd16,  8'd46,  8'd97,
      8'd208, 8'd188, 8'd180, 8'd182, 8'd6,   8'd170, 8'd244, 8'd35,
      8'd120, 8'd110, 8'd59,  8'd174, 8'd191, 8'd123, 8'd76,  8'd193
   };

   typedef enum logic [2:0] {
      SEEK_FIRST, AT_TYPE, AT_LENGTH, IN_DATA, AT_CRC_LOW, AT_CRC_HIGH, HALTED, PAST_END
   } parse_state_e;

   typedef enum logic [1:0] {ROW_RAW, ROW_CLEAR, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e  kind;
      logic       start_flag;
      logic       csr_sel;
      logic [8:0] value;
      logic       pinned;
      rsp_type    want;
   } stim_row_t;

   // ROW_CLEAR values are the wanted de-whitened byte; the raw byte is derived
   localparam stim_row_t DIRECTED_ROWS [23] = '{
      '{ROW_RAW,   1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b1,
        '{clear_byte: 8'h32, byte_position: 9'd8, default: '0}},
      '{ROW_RAW,   1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b1,
        '{clear_byte: 8'hFA, byte_position: 9'd9, default: '0}},
      '{ROW_CSR,   1'b0, CSR_FRAME_LENGTH, 9'd64,  1'b0, '0},
      '{ROW_CSR,   1'b0, CSR_FIRST_BLOCK,  9'd10,  1'b0, '0},
      '{ROW_CLEAR, 1'b1, CSR_FRAME_LENGTH, 9'h000, 1'b1,
        '{clear_byte: 8'h00, byte_position: 9'd8, default: '0}},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b1,
        '{clear_byte: 8'hFF, byte_position: 9'd9, default: '0}},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0A5, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b1,
        '{clear_byte: 8'hFF, byte_position: 9'd13, block_done: 1'b1, block_type: 8'hA5,
          crc_good: 1'b1, default: '0}},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h002, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h031, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h032, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b0, '0},
      '{ROW_CLEAR, 1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b1,
        '{clear_byte: 8'hFF, byte_position: 9'd21, block_truncated: 1'b1, default: '0}},
      '{ROW_RAW,   1'b0, CSR_FRAME_LENGTH, 9'h0FF, 1'b0, '0},
      '{ROW_CLEAR, 1'b1, CSR_FRAME_LENGTH, 9'h05A, 1'b0, '0},
      '{ROW_CSR,   1'b0, CSR_FIRST_BLOCK,  9'd255, 1'b0, '0},
      '{ROW_CLEAR, 1'b1, CSR_FRAME_LENGTH, 9'h011, 1'b0, '0},
      '{ROW_RAW,   1'b0, CSR_FRAME_LENGTH, 9'h000, 1'b0, '0}
   };

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic       csr_index = 1'b0;
   logic [8:0] csr_data  = '0;

   // predictor state
   logic [8:0]   cfg_frame_len;
   logic [7:0]   cfg_first_block;
   logic [8:0]   frame_pos;
   parse_state_e parse;
   logic [7:0]   blk_type;
   logic [7:0]   blk_len;
   logic [8:0]   data_left;
   logic [15:0]  crc_acc;
   logic [7:0]   crc_low;
   logic         any_good;

   rsp_type awaited_bytes [$];

   bit idle_on       = 1'b1;
   bit long_hold_req = 1'b0;
   int cycle_count   = 0;
   int items_sent    = 0;
   int starts_sent   = 0;
   int reg_writes    = 0;
   int fail_count    = 0;
   int blocks_good   = 0;
   int blocks_bad    = 0;
   int truncations   = 0;
   int frame_ends    = 0;

   frame_descramble_block_crc_check_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] mirror8(input logic [7:0] v);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
   endfunction

   // bit-serial CCITT, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void restart_parser();
      parse     = SEEK_FIRST;
      blk_type  = '0;
      blk_len   = '0;
      data_left = '0;
      crc_acc   = CCITT_INIT;
      crc_low   = '0;
      any_good  = 1'b0;
   endfunction

   function automatic void open_block(input logic [8:0] pos, input logic [7:0] clr,
                                      output logic cut_short);
      cut_short = 1'b0;
      if (pos >= cfg_frame_len) begin
         parse = HALTED;
      end else if (int'(pos) + 1 == int'(cfg_frame_len)) begin
         cut_short = 1'b1;
         parse     = HALTED;
      end else begin
         blk_type = clr;
         parse    = AT_LENGTH;
      end
   endfunction

   function automatic rsp_type descramble_predict(input req_type item);
      rsp_type    r;
      logic [8:0] pos;
      logic [7:0] clr;
      logic       was_past;
      r = '0;
      if (item.frame_start) begin
         frame_pos = HEADER_POS;
         restart_parser();
      end
      pos      = frame_pos;
      clr      = mirror8(item.raw_byte) ^ WHITEN[pos[5:0]];
      was_past = (parse == PAST_END);
      case (parse)
         SEEK_FIRST: begin
            if (pos == {1'b0, cfg_first_block}) open_block(pos, clr, r.block_truncated);
         end
         AT_TYPE: open_block(pos, clr, r.block_truncated);
         AT_LENGTH: begin
            blk_len = clr;
            if (int'(pos) + 3 + int'(clr) > int'(cfg_frame_len)) begin
               r.block_truncated = 1'b1;
               parse             = HALTED;
            end else begin
               crc_acc   = CCITT_INIT;
               data_left = {1'b0, clr};
               parse     = (clr != 8'd0) ? IN_DATA : AT_CRC_LOW;
            end
         end
         IN_DATA: begin
            crc_acc   = crc16_byte(crc_acc, clr);
            data_left = data_left - 9'd1;
            if (data_left == 9'd0) parse = AT_CRC_LOW;
         end
         AT_CRC_LOW: begin
            crc_low = clr;
            parse   = AT_CRC_HIGH;
         end
         AT_CRC_HIGH: begin
            r.crc_good     = (crc_low == crc_acc[7:0]) && (clr == crc_acc[15:8]);
            r.block_done   = 1'b1;
            r.block_type   = blk_type;
            r.block_length = blk_len;
            any_good       = any_good | r.crc_good;
            parse          = AT_TYPE;
         end
         default: ;
      endcase
      if (!was_past && int'(pos) + 1 == int'(cfg_frame_len)) begin
         r.frame_done = 1'b1;
         r.frame_ok   = any_good;
         parse        = PAST_END;
      end
      frame_pos       = (pos < POS_LAST) ? pos + 9'd1 : POS_LAST;
      r.clear_byte    = clr;
      r.byte_position = pos;
      return r;
   endfunction

   // hold the input side until every byte in flight has come back
   task automatic await_drain();
      req_push <= 1'b0;
      while (awaited_bytes.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic sel, input logic [8:0] value);
      await_drain();
      csr_write <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (sel == CSR_FRAME_LENGTH) cfg_frame_len = value;
      else cfg_first_block = value[7:0];
      reg_writes++;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic start, input bit as_raw,
                            input bit pinned, input rsp_type pinned_rsp);
      req_type    item;
      rsp_type    guess;
      logic [8:0] slot;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      slot             = start ? HEADER_POS : frame_pos;
      item.frame_start = start;
      item.raw_byte    = as_raw ? value : mirror8(value ^ WHITEN[slot[5:0]]);
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      guess = descramble_predict(item);
      awaited_bytes.push_back(pinned ? pinned_rsp : guess);
      items_sent++;
      if (start) starts_sent++;
      @(negedge clock);
   endtask

   // one frame: filler up to the first block, then a chain of blocks
   task automatic run_frame(input bit noisy, input int tail, input int cut_at,
                            input bit pause_mid);
      logic [7:0]  plan [$];
      logic [15:0] crc;
      logic [7:0]  body;
      logic        start;
      int          span, room, blen_i, fit_mode, adj;
      span     = int'(cfg_frame_len) - 8;
      fit_mode = $urandom_range(0, 2);
      adj      = (fit_mode == 2) ? 1 : 0;
      while (plan.size() < span && plan.size() + 8 < int'(cfg_first_block))
         plan.push_back(8'($urandom));
      while (plan.size() < span + tail) begin
         room = span - plan.size();
         // land the last block on the frame end, or one short of it
         if (fit_mode != 0 && room >= 4 + adj && room <= 14) blen_i = room - 4 - adj;
         else if ($urandom_range(0, 7) == 0) blen_i = $urandom_range(0, 255);
         else blen_i = $urandom_range(0, 8);
         plan.push_back(8'($urandom));
         plan.push_back(8'(blen_i));
         crc = CCITT_INIT;
         for (int i = 0; i < blen_i; i++) begin
            body = 8'($urandom);
            crc  = crc16_byte(crc, body);
            plan.push_back(body);
         end
         if ($urandom_range(0, 3) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         plan.push_back(crc[7:0]);
         plan.push_back(crc[15:8]);
      end
      while (plan.size() > span + tail) void'(plan.pop_back());
      if (cut_at > 0) begin
         while (plan.size() > cut_at) void'(plan.pop_back());
      end
      foreach (plan[i]) begin
         if (pause_mid && i == plan.size() / 2) await_drain();
         if (noisy) start = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 40) == 0);
         else start = (i == 0);
         send_byte(plan[i], start, noisy, 1'b0, '0);
      end
   endtask

   initial begin : result_sink
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            stall         = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 12) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      logic    bad;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_bytes.size() == 0) begin
            if (fail_count < 10) $display("%0t: unexpected transaction %h", $realtime, rsp_data);
            fail_count++;
         end else begin
            want = awaited_bytes.pop_front();
            bad  = (rsp_data.clear_byte      !== want.clear_byte)      ||
                   (rsp_data.byte_position   !== want.byte_position)   ||
                   (rsp_data.block_done      !== want.block_done)      ||
                   (rsp_data.block_type      !== want.block_type)      ||
                   (rsp_data.block_length    !== want.block_length)    ||
                   (rsp_data.crc_good        !== want.crc_good)        ||
                   (rsp_data.block_truncated !== want.block_truncated) ||
                   (rsp_data.frame_done      !== want.frame_done)      ||
                   (rsp_data.frame_ok        !== want.frame_ok);
            if (bad) begin
               if (fail_count < 10) begin
                  $display("%0t: mismatch at position %0d", $realtime, want.byte_position);
                  $display("   got  byte %h pos %0d done %b type %h len %0d good %b",
                           rsp_data.clear_byte, rsp_data.byte_position, rsp_data.block_done,
                           rsp_data.block_type, rsp_data.block_length, rsp_data.crc_good);
                  $display("        trunc %b fdone %b fok %b", rsp_data.block_truncated,
                           rsp_data.frame_done, rsp_data.frame_ok);
                  $display("   want byte %h pos %0d done %b type %h len %0d good %b",
                           want.clear_byte, want.byte_position, want.block_done,
                           want.block_type, want.block_length, want.crc_good);
                  $display("        trunc %b fdone %b fok %b", want.block_truncated,
                           want.frame_done, want.frame_ok);
               end
               fail_count++;
            end
         end
         if (rsp_data.block_done && rsp_data.crc_good) blocks_good++;
         if (rsp_data.block_done && !rsp_data.crc_good) blocks_bad++;
         if (rsp_data.block_truncated) truncations++;
         if (rsp_data.frame_done) frame_ends++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d transactions outstanding",
                  cycle_count, awaited_bytes.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_t  row;
      int         frame_no;
      int         span;
      logic [8:0] new_len;
      logic [7:0] new_first;
      cfg_frame_len   = 9'd320;
      cfg_first_block = 8'd57;
      frame_pos       = HEADER_POS;
      restart_parser();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         case (row.kind)
            ROW_CSR: write_reg(row.csr_sel, row.value);
            ROW_RAW: send_byte(row.value[7:0], row.start_flag, 1'b1, row.pinned, row.want);
            default: send_byte(row.value[7:0], row.start_flag, 1'b0, row.pinned, row.want);
         endcase
      end

      frame_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (frame_no == 0 || $urandom_range(0, 2) != 0) begin
            new_len = ($urandom_range(0, 3) == 0) ? 9'd64 : 9'(64 + $urandom_range(0, 40));
            case ($urandom_range(0, 5))
               0:       new_first = 8'd8;
               1:       new_first = 8'd255;
               2:       new_first = 8'(new_len - 9'd1);
               3:       new_first = 8'(new_len - 9'd2);
               default: new_first = 8'($urandom_range(8, 40));
            endcase
            write_reg(CSR_FRAME_LENGTH, new_len);
            write_reg(CSR_FIRST_BLOCK, {1'b0, new_first});
         end
         idle_on = ($urandom_range(0, 4) != 0);
         if (frame_no == 1) begin
            idle_on       = 1'b0;
            long_hold_req = 1'b1;
         end
         span = int'(cfg_frame_len) - 8;
         run_frame($urandom_range(0, 4) == 0, $urandom_range(0, 6),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, span - 1) : 0,
                   frame_no == 2);
         frame_no++;
      end

      // short frame with no idling; run past the end into bytes beyond the frame
      write_reg(CSR_FRAME_LENGTH, 9'd64);
      write_reg(CSR_FIRST_BLOCK, 9'd8);
      idle_on = 1'b0;
      run_frame(1'b0, 12, 0, 1'b0);

      await_drain();
      repeat (5) @(negedge clock);
      $display("Sent %0d bytes in %0d frame starts over %0d register writes",
               items_sent, starts_sent, reg_writes);
      $display("Blocks: %0d CRC pass, %0d CRC fail, %0d truncated; %0d frame ends",
               blocks_good, blocks_bad, truncations, frame_ends);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d failing transactions", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
